// File: hw/rtl/lcs_pkg.sv
package lcs_pkg;

	// Operation codes carried by an input item
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Capacity register
	localparam int          CAPACITY_BITS  = 5;
	localparam logic [4:0]  CAPACITY_RESET = 5'd16;

	// Control flags of the probe that walks down the chain of cells
	typedef struct packed {
		logic active;     // probe sits at this link in this cycle
		logic found;      // some earlier cell matched the key
		logic have_best;  // an eviction candidate has been chosen
	} lcs_probe_t;

endpackage

// File: hw/rtl/lcs_req_if.sv
interface lcs_req_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [KEY_BITS-1:0]   lookup_key;
	logic [VALUE_BITS-1:0] write_value;

	modport source (output valid, operation, lookup_key, write_value, input ready);
	modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

// File: hw/rtl/lcs_rsp_if.sv
interface lcs_rsp_if #(
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  evicted;

	modport source (output valid, hit, read_value, evicted, input ready);
	modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

// File: hw/rtl/lcs_cell.sv
module lcs_cell #(
	parameter int IDX          = 0,
	parameter int KEY_BITS     = 32,
	parameter int VALUE_BITS   = 32,
	parameter int COUNTER_BITS = 16,
	parameter int OCC_BITS     = 5,
	parameter int IDX_BITS     = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// operation under way, held by the top level
	input  logic                    op_put,
	input  logic [KEY_BITS-1:0]     op_key,
	input  logic [VALUE_BITS-1:0]   op_value,
	input  logic [OCC_BITS-1:0]     occ,
	// fill or replace broadcast
	input  logic                    wr_en,
	input  logic [IDX_BITS-1:0]     wr_idx,
	// probe from the previous cell
	input  lcs_pkg::lcs_probe_t     link_in,
	input  logic [VALUE_BITS-1:0]   rd_in,
	input  logic [COUNTER_BITS-1:0] cnt_in,
	input  logic [COUNTER_BITS-1:0] age_in,
	input  logic [IDX_BITS-1:0]     idx_in,
	// probe to the next cell
	output lcs_pkg::lcs_probe_t     link_out,
	output logic [VALUE_BITS-1:0]   rd_out,
	output logic [COUNTER_BITS-1:0] cnt_out,
	output logic [COUNTER_BITS-1:0] age_out,
	output logic [IDX_BITS-1:0]     idx_out
);

	// Entry storage
	logic [KEY_BITS-1:0]     key_q;
	logic [VALUE_BITS-1:0]   value_q;
	logic [COUNTER_BITS-1:0] count_q;
	logic [COUNTER_BITS-1:0] age_q;

	// Probe registers toward the next cell
	logic                    active_q;
	logic                    found_q;
	logic                    have_best_q;
	logic [VALUE_BITS-1:0]   rd_q;
	logic [COUNTER_BITS-1:0] cnt_q;
	logic [COUNTER_BITS-1:0] best_age_q;
	logic [IDX_BITS-1:0]     idx_q;

	logic                    live;
	logic                    match;
	logic                    take;
	logic [COUNTER_BITS-1:0] aged;
	logic [COUNTER_BITS-1:0] count_inc;

	// Compare this entry against the probe
	always_comb begin
		live      = occ > OCC_BITS'(IDX);
		match     = live && (key_q == op_key);
		aged      = (age_q == '1) ? age_q : age_q + 1'b1;
		count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
		take      = live && (!link_in.have_best || (count_q < cnt_in) ||
			((count_q == cnt_in) && (aged > age_in)));
	end

	// Fill on write-back, otherwise age and bump on the probe's pass
	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IDX_BITS'(IDX))) begin
			key_q   <= op_key;
			value_q <= op_value;
			count_q <= COUNTER_BITS'(1);
			age_q   <= '0;
		end else if (link_in.active && live) begin
			if (match) begin
				age_q   <= '0;
				count_q <= count_inc;
				if (op_put) begin
					value_q <= op_value;
				end
			end else begin
				age_q <= aged;
			end
		end
	end

	// Advance the active flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= link_in.active;
		end
	end

	// Hand the probe on; hold it once it has passed
	always_ff @(posedge clk) begin
		if (link_in.active) begin
			found_q     <= link_in.found | match;
			have_best_q <= link_in.have_best | take;
			rd_q        <= (match && !op_put) ? value_q : rd_in;
			cnt_q       <= take ? count_q : cnt_in;
			best_age_q  <= take ? aged : age_in;
			idx_q       <= take ? IDX_BITS'(IDX) : idx_in;
		end
	end

	assign link_out.active    = active_q;
	assign link_out.found     = found_q;
	assign link_out.have_best = have_best_q;
	assign rd_out             = rd_q;
	assign cnt_out            = cnt_q;
	assign age_out            = best_age_q;
	assign idx_out            = idx_q;

endmodule

// File: hw/rtl/lfu_cache_store_unit.sv
// LFU key/value cache with oldest-first tie-break, DEPTH entries held in a
// row of cells. A get or put is taken only when the unit is idle; a probe
// then walks the cells one per cycle, aging each occupied entry, updating a
// key match and picking the eviction candidate (lowest count, then oldest,
// then lowest slot). A final state then writes a new entry back and loads
// the result, but waits while an earlier result sits untaken in the output
// register; no new item is taken until that state ends, so a waiting
// result does stop the next item. The capacity register (reset 16, clipped
// to DEPTH) is written with cfg_we; the user must write it only while the
// unit is idle, as the block itself does not enforce this. Zero disables
// inserts, and lowering it below the occupancy drops nothing.
module lfu_cache_store_unit #(
	parameter int DEPTH        = 16,
	parameter int KEY_BITS     = 32,
	parameter int VALUE_BITS   = 32,
	parameter int COUNTER_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lcs_pkg::CAPACITY_BITS-1:0] cfg_data,
	lcs_req_if.sink                           req,
	lcs_rsp_if.source                         rsp
);

	localparam int OCC_BITS = $clog2(DEPTH + 1);
	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                        state_q;
	logic [lcs_pkg::CAPACITY_BITS-1:0] capacity_q;
	logic [OCC_BITS-1:0]               occ_q;
	logic                              go_q;
	logic                              op_put_q;
	logic [KEY_BITS-1:0]               op_key_q;
	logic [VALUE_BITS-1:0]             op_value_q;

	logic                  rsp_valid_q;
	logic                  rsp_hit_q;
	logic [VALUE_BITS-1:0] rsp_value_q;
	logic                  rsp_evicted_q;

	// Probe links between cells, link k feeds cell k
	lcs_pkg::lcs_probe_t     link  [DEPTH+1];
	logic [VALUE_BITS-1:0]   rd    [DEPTH+1];
	logic [COUNTER_BITS-1:0] cnt   [DEPTH+1];
	logic [COUNTER_BITS-1:0] age   [DEPTH+1];
	logic [IDX_BITS-1:0]     idx   [DEPTH+1];

	logic                accept;
	logic                finish;
	logic [OCC_BITS-1:0] cap_eff;
	logic                put_miss;
	logic                fill;
	logic                wr_en;
	logic [IDX_BITS-1:0] wr_idx;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// Probe enters at the head of the chain
	assign link[0].active    = go_q;
	assign link[0].found     = 1'b0;
	assign link[0].have_best = 1'b0;
	assign rd[0]             = '0;
	assign cnt[0]            = '0;
	assign age[0]            = '0;
	assign idx[0]            = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lcs_cell #(
			.IDX         (i),
			.KEY_BITS    (KEY_BITS),
			.VALUE_BITS  (VALUE_BITS),
			.COUNTER_BITS(COUNTER_BITS),
			.OCC_BITS    (OCC_BITS),
			.IDX_BITS    (IDX_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op_put   (op_put_q),
			.op_key   (op_key_q),
			.op_value (op_value_q),
			.occ      (occ_q),
			.wr_en    (wr_en),
			.wr_idx   (wr_idx),
			.link_in  (link[i]),
			.rd_in    (rd[i]),
			.cnt_in   (cnt[i]),
			.age_in   (age[i]),
			.idx_in   (idx[i]),
			.link_out (link[i+1]),
			.rd_out   (rd[i+1]),
			.cnt_out  (cnt[i+1]),
			.age_out  (age[i+1]),
			.idx_out  (idx[i+1])
		);
	end

	// Decide the write-back from the probe at the end of the chain
	always_comb begin
		cap_eff  = (32'(capacity_q) > DEPTH) ? OCC_BITS'(DEPTH) : OCC_BITS'(capacity_q);
		finish   = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);
		put_miss = (op_put_q == lcs_pkg::OP_PUT) && !link[DEPTH].found && (cap_eff != '0);
		fill     = occ_q < cap_eff;
		wr_en    = finish && put_miss;
		wr_idx   = fill ? occ_q[IDX_BITS-1:0] : idx[DEPTH];
	end

	// Capture the operation at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			op_put_q   <= req.operation;
			op_key_q   <= req.lookup_key;
			op_value_q <= req.write_value;
		end
	end

	// Sequence the operation and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			go_q       <= 1'b0;
			occ_q      <= '0;
			capacity_q <= lcs_pkg::CAPACITY_RESET;
		end else begin
			go_q <= accept;
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (link[DEPTH].active) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (put_miss && fill) begin
							occ_q <= occ_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_hit_q     <= link[DEPTH].found;
			rsp_value_q   <= rd[DEPTH];
			rsp_evicted_q <= put_miss && !fill;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.evicted    = rsp_evicted_q;

endmodule

// File: tb/lcs_cache_checker.sv
module lcs_cache_checker #(
	parameter int DEPTH        = 16,
	parameter int KEY_BITS     = 32,
	parameter int VALUE_BITS   = 32,
	parameter int COUNTER_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lcs_pkg::CAPACITY_BITS-1:0] cfg_data,
	lcs_req_if                                req,
	lcs_rsp_if                                rsp,
	output int unsigned                       fail_count,
	output int unsigned                       pending,
	output int unsigned                       hit_total,
	output int unsigned                       evict_total
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
	} cache_reply_t;

	// Shadow copy of the cache contents
	logic [KEY_BITS-1:0]     slot_key   [DEPTH];
	logic [VALUE_BITS-1:0]   slot_value [DEPTH];
	logic [COUNTER_BITS-1:0] slot_uses  [DEPTH];
	logic [COUNTER_BITS-1:0] slot_age   [DEPTH];
	int unsigned             fill_level;
	logic [lcs_pkg::CAPACITY_BITS-1:0] capacity_reg;

	cache_reply_t expected_replies [$];
	int unsigned  reply_index;

	// Age every occupied entry, update a key match, then insert or replace on a put miss
	task automatic apply_access(input logic op, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] val, output cache_reply_t res);
		int unsigned eff_cap;
		int unsigned occ;
		int unsigned victim;
		res = '0;
		eff_cap = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
		occ = fill_level;
		for (int i = 0; i < occ; i++) begin
			if (slot_age[i] != CTR_MAX)
				slot_age[i] = slot_age[i] + 1'b1;
			if (slot_key[i] == key) begin
				res.hit = 1'b1;
				if (op == lcs_pkg::OP_PUT)
					slot_value[i] = val;
				else
					res.read_value = slot_value[i];
				if (slot_uses[i] != CTR_MAX)
					slot_uses[i] = slot_uses[i] + 1'b1;
				slot_age[i] = '0;
			end
		end
		if (op == lcs_pkg::OP_PUT && !res.hit && eff_cap != 0) begin
			if (occ < eff_cap) begin
				victim = occ;
				fill_level = occ + 1;
			end else begin
				// Lowest count first, then oldest, then lowest slot
				victim = 0;
				for (int i = 1; i < occ; i++) begin
					if (slot_uses[i] < slot_uses[victim] ||
							(slot_uses[i] == slot_uses[victim] &&
							slot_age[i] > slot_age[victim]))
						victim = i;
				end
				res.evicted = 1'b1;
			end
			slot_key[victim]   = key;
			slot_value[victim] = val;
			slot_uses[victim]  = COUNTER_BITS'(1);
			slot_age[victim]   = '0;
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on reply %0d: %s got 0x%0h expected 0x%0h",
			reply_index, field, got, want);
		fail_count++;
	endtask

	// Track config writes, predict on accepted requests, compare accepted replies
	always @(posedge clk or negedge arst_n) begin
		cache_reply_t want;
		cache_reply_t res;
		if (!arst_n) begin
			fill_level   = 0;
			capacity_reg = lcs_pkg::CAPACITY_RESET;
			expected_replies.delete();
			reply_index  = 0;
			fail_count   = 0;
			hit_total    = 0;
			evict_total  = 0;
			pending      = 0;
		end else begin
			if (cfg_we)
				capacity_reg = cfg_data;
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("reply with nothing outstanding", 64'(rsp.hit), 64'(0));
				end else begin
					want = expected_replies.pop_front();
					if (rsp.hit !== want.hit)
						report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", 64'(rsp.read_value),
							64'(want.read_value));
					if (rsp.evicted !== want.evicted)
						report_mismatch("evicted", 64'(rsp.evicted), 64'(want.evicted));
				end
				reply_index++;
			end
			if (req.valid && req.ready) begin
				apply_access(req.operation, req.lookup_key, req.write_value, res);
				if (res.hit)
					hit_total++;
				if (res.evicted)
					evict_total++;
				expected_replies.push_back(res);
			end
			pending = expected_replies.size();
		end
	end

endmodule

// File: tb/tb_lfu_cache_store_unit.sv
module tb_lfu_cache_store_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int      DEPTH        = 16;
	localparam int      KEY_BITS     = 32;
	localparam int      VALUE_BITS   = 32;
	localparam int      COUNTER_BITS = 16;
	localparam int      LATENCY      = DEPTH + 3;
	localparam int      POOL_SIZE    = 24;
	localparam int      PHASE_ITEMS  = 70;
	localparam int      LONG_HOLD    = 300;
	localparam int      HOT_READS    = 20;
	localparam longint  CYCLE_LIMIT  = 4_000_000;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [lcs_pkg::CAPACITY_BITS-1:0] cfg_data;

	lcs_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
	lcs_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_ch ();

	int unsigned     fail_count;
	int unsigned     pending;
	int unsigned     hit_total;
	int unsigned     evict_total;
	bit              quiet_mode;
	int unsigned     items_sent;
	int unsigned     cfg_writes;
	longint unsigned cycle_count;
	logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

	lfu_cache_store_unit #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	lcs_cache_checker #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.pending(pending),
		.hit_total(hit_total),
		.evict_total(evict_total)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one item after a random gap, hold it until accepted
	task automatic send(input logic op, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] val);
		int unsigned gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.lookup_key  <= key;
		req_ch.write_value <= val;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		@(negedge clk);
		items_sent++;
	endtask

	// Drain the block, then write the capacity register
	task automatic write_capacity(input logic [lcs_pkg::CAPACITY_BITS-1:0] cap);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// Accept replies after random gaps; hold off twice for a long stretch
	initial begin : reply_sink
		int unsigned gap;
		int unsigned rsp_taken;
		rsp_ch.ready = 1'b0;
		rsp_taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = quiet_mode ? 0 : $urandom_range(0, 17);
			if (rsp_taken == 60 || rsp_taken == 400)
				gap = LONG_HOLD;
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			rsp_taken++;
		end
	end

	initial begin : stimulus
		int unsigned eff_cap;
		int unsigned span;
		logic [KEY_BITS-1:0] hot_key;
		logic [lcs_pkg::CAPACITY_BITS-1:0] phase_caps [8];

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_data           = lcs_pkg::CAPACITY_RESET;
		req_ch.valid       = 1'b0;
		req_ch.operation   = lcs_pkg::OP_GET;
		req_ch.lookup_key  = '0;
		req_ch.write_value = '0;
		quiet_mode         = 1'b0;
		items_sent         = 0;
		cfg_writes         = 0;
		cycle_count        = 0;
		hot_key            = 32'hC0DE_0001;
		phase_caps = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd16, 5'd12};
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty cache, extreme keys and values, update in place
		send(lcs_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
		send(lcs_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send(lcs_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send(lcs_pkg::OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
		send(lcs_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send(lcs_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
		send(lcs_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);

		// Full cache: replace by lowest count
		write_capacity(5'd2);
		send(lcs_pkg::OP_PUT, 32'hAAAA_5555, 32'h0000_0001);
		send(lcs_pkg::OP_PUT, 32'h5555_AAAA, 32'h0000_0002);
		send(lcs_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
		send(lcs_pkg::OP_PUT, 32'h0F0F_0F0F, 32'h0000_0003);

		// Zero capacity: no inserts, hits still served
		write_capacity(5'd0);
		send(lcs_pkg::OP_PUT, 32'h7777_7777, 32'h0000_0004);
		send(lcs_pkg::OP_GET, 32'h7777_7777, 32'h0000_0000);
		send(lcs_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0005);
		send(lcs_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);

		// Capacity above depth, then lowered below occupancy
		write_capacity(5'd31);
		for (int i = 0; i < 4; i++)
			send(lcs_pkg::OP_PUT, 32'h1000_0000 + i, 32'h8000_0000 | i);
		write_capacity(5'd1);
		send(lcs_pkg::OP_PUT, 32'h2000_0000, 32'h8000_0000);
		send(lcs_pkg::OP_GET, 32'h1000_0002, 32'h0000_0000);
		send(lcs_pkg::OP_GET, 32'h2000_0000, 32'h0000_0000);

		// Random traffic over a small key pool, with some fully random noise
		for (int p = 0; p < 8; p++) begin
			write_capacity(phase_caps[p]);
			quiet_mode <= (p == 5);
			eff_cap = (phase_caps[p] > DEPTH) ? DEPTH : phase_caps[p];
			span = eff_cap * 2 + 2;
			if (span > POOL_SIZE)
				span = POOL_SIZE;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 8)
					send(1'($urandom_range(0, 1)), $urandom, $urandom);
				else
					send(1'($urandom_range(0, 1)), key_pool[$urandom_range(0, span - 1)],
						$urandom);
			end
		end

		// Raise one entry's count well above the rest, then force replacements
		quiet_mode <= 1'b1;
		write_capacity(lcs_pkg::CAPACITY_RESET);
		send(lcs_pkg::OP_PUT, hot_key, $urandom);
		repeat (HOT_READS)
			send(lcs_pkg::OP_GET, hot_key, $urandom);
		send(lcs_pkg::OP_PUT, hot_key, $urandom);
		repeat (4)
			send(lcs_pkg::OP_PUT, $urandom, $urandom);
		send(lcs_pkg::OP_GET, hot_key, $urandom);
		quiet_mode <= 1'b0;

		// Drain and let the block settle
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2 * LATENCY) @(negedge clk);

		$display("run covered %0d items across %0d capacity writes, with fill, eviction",
			items_sent, cfg_writes);
		$display("zero and oversize capacity and long output stalls; predicted %0d hits, %0d evictions",
			hit_total, evict_total);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
